>>> hdl/lkd_pkg.sv
// Shared types and constants for the LRU keyed line directory.
// Used by lkd_ctrl, lkd_datapath and lru_keyed_line_directory; no dependencies.
package lkd_pkg;

	localparam int LINES_DEF    = 16;
	localparam int KEY_BITS_DEF = 64;
	localparam int KEY_IN_W     = 64;
	localparam int STAMP_W      = 32;
	localparam int OUT_IDX_W    = 4;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;    // latch the request, restart the scan
		logic scan_en;  // step through the lines
		logic commit;   // write back and load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done; // last line's read data is being compared
		logic out_free;  // result register can take a new item
	} sts_t;

endpackage

>>> hdl/lru_keyed_line_directory.sv
// Top level of the LRU keyed line directory; instantiates lkd_ctrl and
// lkd_datapath, parameter defaults from lkd_pkg.
//
// Tag directory of a fully associative cache with LINES lines. A lookup
// (opcode 0) reports the first valid line whose key matches and restamps it
// with now; an insert (opcode 1) replaces the lowest-indexed line with the
// smallest stamp, without a duplicate check. Every item yields one result.
// An item is accepted, then the lines are stepped through the single read
// port of the key/stamp memories with a registered read, then the item is
// written back and the result register loaded once that register is free.
// The next item is accepted while a result waits on out_stall.
// Valid bits clear at reset; no clearing pass is needed.
module lru_keyed_line_directory #(
	parameter int LINES    = lkd_pkg::LINES_DEF,
	parameter int KEY_BITS = lkd_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [lkd_pkg::KEY_IN_W-1:0]  lookup_key,
	input  logic [lkd_pkg::STAMP_W-1:0]   now,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [lkd_pkg::OUT_IDX_W-1:0] line_index
);

	lkd_pkg::cmd_t cmd;
	lkd_pkg::sts_t sts;

	lkd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkd_datapath #(
		.LINES    (LINES),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.now        (now),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.line_index (line_index)
	);

endmodule

>>> hdl/lkd_ctrl.sv
// Controller for the LRU keyed line directory: request sequencing.
// Depends on lkd_pkg (state_t, cmd_t, sts_t).
module lkd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  lkd_pkg::sts_t sts,
	output lkd_pkg::cmd_t cmd
);

	lkd_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lkd_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = lkd_pkg::ST_SCAN;
			end
			lkd_pkg::ST_SCAN: begin
				if (sts.scan_done) state_nxt = lkd_pkg::ST_COMMIT;
			end
			lkd_pkg::ST_COMMIT: begin
				if (sts.out_free) state_nxt = lkd_pkg::ST_IDLE;
			end
			default: state_nxt = lkd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			lkd_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			lkd_pkg::ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			lkd_pkg::ST_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/lkd_datapath.sv
// Datapath for the LRU keyed line directory: key and stamp memories,
// valid bits, scan counter, match/victim compare and result register. Depends on lkd_pkg.
module lkd_datapath #(
	parameter int LINES    = lkd_pkg::LINES_DEF,
	parameter int KEY_BITS = lkd_pkg::KEY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkd_pkg::cmd_t                     cmd,
	output lkd_pkg::sts_t                     sts,
	input  logic                              opcode,
	input  logic [lkd_pkg::KEY_IN_W-1:0]      lookup_key,
	input  logic [lkd_pkg::STAMP_W-1:0]       now,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [lkd_pkg::OUT_IDX_W-1:0]     line_index
);

	localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int CNT_W = IDX_W + 1;

	// request
	logic                        op_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [lkd_pkg::STAMP_W-1:0] now_q;

	// storage
	logic [KEY_BITS-1:0]         key_mem   [LINES];
	logic [lkd_pkg::STAMP_W-1:0] stamp_mem [LINES];
	logic [LINES-1:0]            valid_q;

	// scan
	logic [CNT_W-1:0]            rd_cnt_q;
	logic [IDX_W-1:0]            rd_addr;
	logic                        rd_go;
	logic                        rd_vld_s1;
	logic [IDX_W-1:0]            rd_idx_s1;
	logic [KEY_BITS-1:0]         key_rd_s1;
	logic [lkd_pkg::STAMP_W-1:0] stamp_rd_s1;
	logic                        line_vld_s1;
	logic [lkd_pkg::STAMP_W-1:0] stamp_eff;

	// compare results
	logic                        found_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [lkd_pkg::STAMP_W-1:0] best_stamp_q;

	// result register
	logic                        out_valid_q;
	logic                        hit_q;
	logic [lkd_pkg::OUT_IDX_W-1:0] idx_q;

	logic wr_key;
	logic wr_stamp;

	assign rd_addr = rd_cnt_q[IDX_W-1:0];
	assign rd_go   = cmd.scan_en && (rd_cnt_q < CNT_W'(LINES));

	// a line never written counts as holding a stamp of zero
	assign stamp_eff = line_vld_s1 ? stamp_rd_s1 : '0;

	assign wr_key   = cmd.commit && (op_q == lkd_pkg::OP_INSERT);
	assign wr_stamp = cmd.commit && ((op_q == lkd_pkg::OP_INSERT) || found_q);

	assign sts.scan_done = rd_vld_s1 && (rd_idx_s1 == IDX_W'(LINES - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= opcode;
			key_q <= lookup_key[KEY_BITS-1:0];
			now_q <= now;
		end
	end

	// key/stamp memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_key) key_mem[best_idx_q] <= key_q;
		if (wr_stamp) stamp_mem[best_idx_q] <= now_q;
		if (rd_go) begin
			key_rd_s1   <= key_mem[rd_addr];
			stamp_rd_s1 <= stamp_mem[rd_addr];
			line_vld_s1 <= valid_q[rd_addr];
			rd_idx_s1   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (wr_key) valid_q[best_idx_q] <= 1'b1;
			if (cmd.start) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
			end else if (rd_go) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= rd_go;
			if (rd_vld_s1 && (op_q == lkd_pkg::OP_LOOKUP) && !found_q && line_vld_s1 &&
			    (key_rd_s1 == key_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	// first match for lookup, lowest-indexed oldest stamp for insert
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (op_q == lkd_pkg::OP_LOOKUP) begin
				if (!found_q && line_vld_s1 && (key_rd_s1 == key_q)) best_idx_q <= rd_idx_s1;
			end else if ((rd_idx_s1 == '0) || (stamp_eff < best_stamp_q)) begin
				best_idx_q   <= rd_idx_s1;
				best_stamp_q <= stamp_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= (op_q == lkd_pkg::OP_LOOKUP) && found_q;
			idx_q <= ((op_q == lkd_pkg::OP_INSERT) || found_q) ?
			         lkd_pkg::OUT_IDX_W'(best_idx_q) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign line_index = idx_q;

	ap_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_vld_s1 && (rd_cnt_q == CNT_W'(LINES)))
		else $error("write-back while scan still running");

	ap_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		sts.scan_done |-> (rd_cnt_q == CNT_W'(LINES)))
		else $error("scan finished before all lines were read");

	ap_insert_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == lkd_pkg::OP_INSERT) |=> out_valid_q && !hit_q)
		else $error("insert reported a hit");

	ap_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_key |=> valid_q[$past(best_idx_q)])
		else $error("inserted line not marked valid");

endmodule
